@@ rtl/brl_pkg.sv @@
package brl_pkg;

  // Command codes on the head interface
  typedef enum logic [1:0] {
    CMD_PUNCH  = 2'd0,
    CMD_MOVE_Y = 2'd1,
    CMD_MOVE_X = 2'd2
  } brl_cmd_e;

  localparam int unsigned CellW   = 6;
  localparam int unsigned CharW   = 8;
  localparam int unsigned DotW    = 8;
  localparam int unsigned SpaceW  = 10;
  localparam int unsigned StepsW  = 11;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CharW-1:0] CHAR_FIRST = 8'h41;
  localparam logic [CharW-1:0] CHAR_LAST  = 8'h5A;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DOT_SPACING  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHAR_SPACING = 2'd1;

  localparam logic [DotW-1:0]   DOT_SPACING_RST  = 8'd15;
  localparam logic [SpaceW-1:0] CHAR_SPACING_RST = 10'd30;

  // Slots of one character run, in emission order
  localparam logic [SlotW-1:0] SLOT_DOT0  = 4'd0;
  localparam logic [SlotW-1:0] SLOT_Y01   = 4'd1;
  localparam logic [SlotW-1:0] SLOT_DOT1  = 4'd2;
  localparam logic [SlotW-1:0] SLOT_Y12   = 4'd3;
  localparam logic [SlotW-1:0] SLOT_DOT2  = 4'd4;
  localparam logic [SlotW-1:0] SLOT_YRET0 = 4'd5;
  localparam logic [SlotW-1:0] SLOT_XCOL  = 4'd6;
  localparam logic [SlotW-1:0] SLOT_DOT3  = 4'd7;
  localparam logic [SlotW-1:0] SLOT_Y34   = 4'd8;
  localparam logic [SlotW-1:0] SLOT_DOT4  = 4'd9;
  localparam logic [SlotW-1:0] SLOT_Y45   = 4'd10;
  localparam logic [SlotW-1:0] SLOT_DOT5  = 4'd11;
  localparam logic [SlotW-1:0] SLOT_YRET1 = 4'd12;
  localparam logic [SlotW-1:0] SLOT_XBACK = 4'd13;
  localparam logic [SlotW-1:0] SLOT_XNEXT = 4'd14;

  typedef struct packed {
    logic full;
    logic empty;
  } brl_q_status_t;

  // Cell patterns for A..Z, bit k = dot k. Not standard Braille (S = T).
  function automatic logic [CellW-1:0] cell_of(input logic [4:0] idx);
    logic [CellW-1:0] c;
    unique case (idx)
      5'd0:    c = 6'h02;
      5'd1:    c = 6'h0A;
      5'd2:    c = 6'h03;
      5'd3:    c = 6'h07;
      5'd4:    c = 6'h06;
      5'd5:    c = 6'h0B;
      5'd6:    c = 6'h0F;
      5'd7:    c = 6'h0E;
      5'd8:    c = 6'h05;
      5'd9:    c = 6'h0D;
      5'd10:   c = 6'h22;
      5'd11:   c = 6'h2A;
      5'd12:   c = 6'h23;
      5'd13:   c = 6'h27;
      5'd14:   c = 6'h26;
      5'd15:   c = 6'h2B;
      5'd16:   c = 6'h2F;
      5'd17:   c = 6'h2E;
      5'd18:   c = 6'h2D;
      5'd19:   c = 6'h2D;
      5'd20:   c = 6'h32;
      5'd21:   c = 6'h3A;
      5'd22:   c = 6'h1D;
      5'd23:   c = 6'h33;
      5'd24:   c = 6'h37;
      5'd25:   c = 6'h36;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/brl_front.sv @@
module brl_front (
  input  logic                          start_i,
  input  logic [brl_pkg::CharW-1:0]     character_i,
  input  brl_pkg::brl_q_status_t        q_status_i,
  output logic                          busy_o,
  output logic                          push_o,
  output logic [brl_pkg::CellW-1:0]     cell_o
);
  import brl_pkg::*;

  logic             is_letter;
  logic [CharW-1:0] offset;

  assign is_letter = (character_i >= CHAR_FIRST) && (character_i <= CHAR_LAST);
  assign offset    = character_i - CHAR_FIRST;
  assign cell_o    = cell_of(offset[4:0]);

  // non-letters are taken and dropped here
  assign busy_o = q_status_i.full;
  assign push_o = start_i && !q_status_i.full && is_letter;

endmodule

@@ rtl/brl_queue.sv @@
module brl_queue #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [Width-1:0]       data_i,
  input  logic                   pop_i,
  output logic [Width-1:0]       data_o,
  output brl_pkg::brl_q_status_t status_o
);
  import brl_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);

endmodule

@@ rtl/brl_back.sv @@
module brl_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  brl_pkg::brl_q_status_t        q_status_i,
  input  logic [brl_pkg::CellW-1:0]     q_cell_i,
  input  logic [brl_pkg::DotW-1:0]      dot_spacing_i,
  input  logic [brl_pkg::SpaceW-1:0]    char_spacing_i,
  output logic                          pop_o,
  output logic                          result_valid_o,
  output logic [1:0]                    command_o,
  output logic signed [brl_pkg::StepsW-1:0] move_steps_o,
  output logic                          last_o
);
  import brl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } brl_back_state_e;

  brl_back_state_e  state_q, state_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [CellW-1:0] cell_q, cell_d;

  // a punch slot whose dot is clear is passed over
  function automatic logic skipped(input logic [SlotW-1:0] s, input logic [CellW-1:0] c);
    logic r;
    unique case (s)
      SLOT_DOT0: r = !c[0];
      SLOT_DOT1: r = !c[1];
      SLOT_DOT2: r = !c[2];
      SLOT_DOT3: r = !c[3];
      SLOT_DOT4: r = !c[4];
      SLOT_DOT5: r = !c[5];
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

  logic [SlotW-1:0] first_slot, step1, step2, next_slot;

  assign first_slot = skipped(SLOT_DOT0, q_cell_i) ? SLOT_Y01 : SLOT_DOT0;
  assign step1      = slot_q + 1'b1;
  assign step2      = slot_q + 4'd2;
  assign next_slot  = skipped(step1, cell_q) ? step2 : step1;

  always_comb begin
    state_d = state_q;
    slot_d  = slot_q;
    cell_d  = cell_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          cell_d  = q_cell_i;
          slot_d  = first_slot;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (slot_q == SLOT_XNEXT) begin
          if (!q_status_i.empty) begin
            pop_o  = 1'b1;
            cell_d = q_cell_i;
            slot_d = first_slot;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          slot_d = next_slot;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= SLOT_DOT0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  logic signed [StepsW-1:0] d_pos, d_neg, d2_neg, cs_pos;
  brl_cmd_e                 cmd;

  assign d_pos  = $signed({3'b000, dot_spacing_i});
  assign d_neg  = -d_pos;
  assign d2_neg = -$signed({2'b00, dot_spacing_i, 1'b0});
  assign cs_pos = $signed({1'b0, char_spacing_i});

  always_comb begin
    cmd          = CMD_PUNCH;
    move_steps_o = '0;
    last_o       = 1'b0;
    unique case (slot_q)
      SLOT_Y01, SLOT_Y12, SLOT_Y34, SLOT_Y45: begin
        cmd          = CMD_MOVE_Y;
        move_steps_o = d_pos;
      end
      SLOT_YRET0, SLOT_YRET1: begin
        cmd          = CMD_MOVE_Y;
        move_steps_o = d2_neg;
      end
      SLOT_XCOL: begin
        cmd          = CMD_MOVE_X;
        move_steps_o = d_pos;
      end
      SLOT_XBACK: begin
        cmd          = CMD_MOVE_X;
        move_steps_o = d_neg;
      end
      SLOT_XNEXT: begin
        cmd          = CMD_MOVE_X;
        move_steps_o = cs_pos;
        last_o       = 1'b1;
      end
      default: begin
        cmd          = CMD_PUNCH;
        move_steps_o = '0;
      end
    endcase
  end

  assign command_o      = cmd;
  assign result_valid_o = (state_q == ST_RUN);

endmodule

@@ rtl/braille_emboss_command_sequencer.sv @@
// Braille embossing command sequencer. Each request on start_i carries one
// character byte; it is taken on a clock edge with start_i high and busy_o
// low. Bytes outside 'A'..'Z' are taken and produce nothing. A letter
// expands into 10 to 14 head commands (9 moves plus one punch per raised
// dot), issued one per cycle on result_valid_o with last_o on the final X
// advance. The receiver cannot stall: every command is shown for exactly
// one cycle. The command sequencer issues one command per cycle; a queue
// of QueueDepth letters sits in front of it, letters run back to back with
// no gap while the queue holds the next, and busy_o rises only while that
// queue is full. Spacing registers are written via cfg_valid_i/cfg_ready_o
// (always ready) and must only change while idle.
module braille_emboss_command_sequencer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // character requests
  input  logic                                  start_i,
  input  logic [brl_pkg::CharW-1:0]             character_i,
  output logic                                  busy_o,
  // head commands
  output logic                                  result_valid_o,
  output logic [1:0]                            command_o,
  output logic signed [brl_pkg::StepsW-1:0]     move_steps_o,
  output logic                                  last_o,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [brl_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [brl_pkg::SpaceW-1:0]            cfg_data_i
);
  import brl_pkg::*;

  // Spacing registers
  logic [DotW-1:0]   dot_spacing_q;
  logic [SpaceW-1:0] char_spacing_q;

  assign cfg_ready_o = 1'b1;

  // unknown indexes are dropped; the dot spacing keeps only the low DotW bits of the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_spacing_q  <= DOT_SPACING_RST;
      char_spacing_q <= CHAR_SPACING_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_DOT_SPACING) begin
        dot_spacing_q <= cfg_data_i[DotW-1:0];
      end
      if (cfg_index_i == CFG_CHAR_SPACING) begin
        char_spacing_q <= cfg_data_i;
      end
    end
  end

  // Front end: letter check and cell lookup
  brl_q_status_t    q_status;
  logic             push;
  logic             pop;
  logic [CellW-1:0] push_cell;
  logic [CellW-1:0] head_cell;

  brl_front u_front (
    .start_i     (start_i),
    .character_i (character_i),
    .q_status_i  (q_status),
    .busy_o      (busy_o),
    .push_o      (push),
    .cell_o      (push_cell)
  );

  // Cell queue between the two halves
  brl_queue #(
    .Depth (QueueDepth),
    .Width (CellW)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_cell),
    .pop_i    (pop),
    .data_o   (head_cell),
    .status_o (q_status)
  );

  // Back end: walks the command slots of one cell
  brl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .q_cell_i       (head_cell),
    .dot_spacing_i  (dot_spacing_q),
    .char_spacing_i (char_spacing_q),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .command_o      (command_o),
    .move_steps_o   (move_steps_o),
    .last_o         (last_o)
  );

  // Checks
  a_last_is_x_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |->
      command_o == CMD_MOVE_X && move_steps_o == $signed({1'b0, char_spacing_q}))
    else $error("last command is not the character advance");

  a_punch_no_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && command_o == CMD_PUNCH |-> move_steps_o == '0)
    else $error("punch carries a step count");

  a_pop_starts_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> result_valid_o)
    else $error("dequeued cell did not start a run");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.full && !pop |=> !push || $past(busy_o))
    else $error("cell queue overflow");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import brl_pkg::*;

  // Clock and reset
  localparam int unsigned HalfPeriod  = 2;
  localparam int unsigned ResetCycles = 12;
  // Generous ceiling: 222 character requests and their commands, plus drains
  localparam int unsigned CycleLimit  = 200_000;
  // Extra idle wait in drain after the last owed command shows up,
  // before anything touches the registers
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxReported  = 10;
  localparam int unsigned PhaseItems   = 34;
  localparam int unsigned RandPhases   = 6;

  // Register indexes the block does not implement: writes must be dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

  // Marks a directed row whose command count is not typed in
  localparam int NoTally = -1;

  // Six-dot cell for each of A..Z; bit k raised = dot k punched.
  // Held exactly as cell_of in brl_pkg has it (S and T are identical).
  localparam logic [CellW-1:0] CellPatterns [26] = '{
    6'h02, 6'h0A, 6'h03, 6'h07, 6'h06, 6'h0B, 6'h0F, 6'h0E, 6'h05, 6'h0D,
    6'h22, 6'h2A, 6'h23, 6'h27, 6'h26, 6'h2B, 6'h2F, 6'h2E, 6'h2D, 6'h2D,
    6'h32, 6'h3A, 6'h1D, 6'h33, 6'h37, 6'h36
  };

  typedef struct packed {
    brl_cmd_e                  cmd;
    logic signed [StepsW-1:0]  steps;
    logic                      last;
  } head_cmd_t;

  typedef enum logic {
    ROW_CHAR,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  index;
    logic [SpaceW-1:0]   value;
    int                  tally;   // typed command count of the run, or NoTally
  } script_row_t;

  // DUT-facing signals; the ones driven here are known from time zero
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start_i     = 1'b0;
  logic [CharW-1:0]         character_i = '0;
  logic                     cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [SpaceW-1:0]        cfg_data_i  = '0;
  logic                     busy_o;
  logic                     result_valid_o;
  logic [1:0]               command_o;
  logic signed [StepsW-1:0] move_steps_o;
  logic                     last_o;
  logic                     cfg_ready_o;

  // Shadow copy of the spacing registers, tracked on every accepted write
  logic [DotW-1:0]   dot_pitch  = DOT_SPACING_RST;
  logic [SpaceW-1:0] char_pitch = CHAR_SPACING_RST;

  head_cmd_t   pending_cmds [$];   // head commands still owed by the block
  int          run_tallies  [$];   // typed run lengths, one per accepted letter
  int          next_tally   = NoTally;
  int          run_count    = 0;
  int unsigned cmd_seen     = 0;
  int unsigned fault_count  = 0;
  int unsigned cycle_count  = 0;

  script_row_t script [26];

  braille_emboss_command_sequencer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .character_i    (character_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .command_o      (command_o),
    .move_steps_o   (move_steps_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic void owe_cmd(input brl_cmd_e cmd, input logic signed [StepsW-1:0] steps,
                                  input logic last);
    head_cmd_t c;
    c.cmd   = cmd;
    c.steps = steps;
    c.last  = last;
    pending_cmds.push_back(c);
  endfunction

  // Expands one character byte into the head commands it should produce
  // under the current spacing. Returns 1 when the byte is a letter.
  function automatic bit expand_letter(input logic [CharW-1:0] ch);
    logic [CellW-1:0]         dots;
    logic signed [StepsW-1:0] pitch;
    if (ch < CHAR_FIRST || ch > CHAR_LAST) begin
      return 1'b0;
    end
    dots  = CellPatterns[ch - CHAR_FIRST];
    pitch = {{(StepsW-DotW){1'b0}}, dot_pitch};
    for (int col = 0; col < 2; col++) begin
      // walk down the column, punching raised dots
      for (int row = 0; row < 3; row++) begin
        if (dots[col*3 + row]) begin
          owe_cmd(CMD_PUNCH, '0, 1'b0);
        end
        if (row < 2) begin
          owe_cmd(CMD_MOVE_Y, pitch, 1'b0);
        end
      end
      // head back to the top row; step across only after the left column
      owe_cmd(CMD_MOVE_Y, -(pitch <<< 1), 1'b0);
      if (col == 0) begin
        owe_cmd(CMD_MOVE_X, pitch, 1'b0);
      end
    end
    owe_cmd(CMD_MOVE_X, -pitch, 1'b0);
    owe_cmd(CMD_MOVE_X, {1'b0, char_pitch}, 1'b1);
    return 1'b1;
  endfunction

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= MaxReported) begin
      $display("%s", what);
    end
  endtask

  // Scoreboard: everything is sampled at the rising edge, so register
  // writes, accepted requests and head commands are seen as the block sees them
  always @(posedge clk_i) begin
    head_cmd_t want;
    int        tally;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DOT_SPACING: begin
            dot_pitch = cfg_data_i[DotW-1:0];  // upper bits are dropped
          end
          CFG_CHAR_SPACING: begin
            char_pitch = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      // predict before checking; a request's cell is queued before it is run
      if (start_i && !busy_o) begin
        if (expand_letter(character_i)) begin
          run_tallies.push_back(next_tally);
        end
      end
      if (result_valid_o === 1'b1) begin
        cmd_seen++;
        run_count++;
        if (pending_cmds.size() == 0) begin
          note_fault($sformatf("command %0d: unexpected (command %0d, steps %0d, last %b)",
                               cmd_seen, command_o, move_steps_o, last_o));
        end else begin
          want = pending_cmds.pop_front();
          if (command_o !== want.cmd) begin
            note_fault($sformatf("command %0d: command expected %0d, got %0d",
                                 cmd_seen, want.cmd, command_o));
          end
          if (move_steps_o !== want.steps) begin
            note_fault($sformatf("command %0d: move_steps expected %0d, got %0d",
                                 cmd_seen, want.steps, move_steps_o));
          end
          if (last_o !== want.last) begin
            note_fault($sformatf("command %0d: last expected %b, got %b",
                                 cmd_seen, want.last, last_o));
          end
        end
        // typed run lengths from the directed table are checked on last
        if (last_o === 1'b1) begin
          if (run_tallies.size() != 0) begin
            tally = run_tallies.pop_front();
            if (tally != NoTally && tally != run_count) begin
              note_fault($sformatf("command %0d: run length expected %0d, got %0d",
                                   cmd_seen, tally, run_count));
            end
          end
          run_count = 0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("braille_emboss_command_sequencer verification failed");
      $finish;
    end
  end

  // One character request; returns at the edge that took it, then idles
  // for the drawn gap. With no gap start_i stays high for the next request.
  task automatic send_char(input logic [CharW-1:0] ch, input int unsigned gap,
                           input int tally);
    start_i     <= 1'b1;
    character_i <= ch;
    next_tally  <= tally;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending, wait for every owed command, then wait SettleCycles more
  // before anything touches the registers
  task automatic drain;
    start_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [SpaceW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [CharW-1:0] ch;
    int unsigned      gap;
    int unsigned      burst_left;
    bit               idle_on;

    // Directed part. Run lengths typed in where they follow straight from
    // the cell (9 moves + one punch per raised dot) or are nil for non-letters.
    script = '{
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h041, 10},        // 'A' after reset, one dot
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h040, 0},         // '@', just below the range
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h05A, 13},        // 'Z', top of the range
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h05B, 0},         // '[', just above
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h000, 0},
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h0FF, 0},
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h0C1, 0},         // 'A' with bit 7 set
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h061, 0},         // lower-case 'a'
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h047, 13},        // 'G', full left column
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h051, 14},        // 'Q', one of the two densest cells
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h053, NoTally},   // 'S' and 'T' share a cell
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h054, NoTally},
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h057, NoTally},   // 'W'
      '{ROW_REG,  CFG_DOT_SPACING, 10'h3FF, NoTally},   // over-wide value, keeps 255
      '{ROW_REG,  CFG_CHAR_SPACING, 10'h3FF, NoTally},
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h059, 14},        // 'Y' at the widest spacing
      '{ROW_REG,  CFG_SPARE_2, 10'h155, NoTally},       // unknown indexes ignored
      '{ROW_REG,  CFG_SPARE_3, 10'h2AA, NoTally},
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h04D, NoTally},   // 'M'
      '{ROW_REG,  CFG_DOT_SPACING, 10'h000, NoTally},   // zero spacing: moves of 0
      '{ROW_REG,  CFG_CHAR_SPACING, 10'h000, NoTally},
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h051, 14},
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h049, NoTally},   // 'I'
      '{ROW_REG,  CFG_DOT_SPACING, 10'h001, NoTally},
      '{ROW_REG,  CFG_CHAR_SPACING, 10'h001, NoTally},
      '{ROW_CHAR, CFG_DOT_SPACING, 10'h04B, NoTally}    // 'K'
    };

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        drain();
        write_reg(script[i].index, script[i].value);
      end else begin
        send_char(script[i].value[CharW-1:0], 0, script[i].tally);
      end
    end

    // Random part: mostly letters, the rest any byte. Idling comes in
    // bursts so that back-to-back stretches alternate with gappy ones.
    burst_left = 0;
    idle_on    = 1'b0;
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain();
      case (ph)
        1: begin
          write_reg(CFG_DOT_SPACING, 10'h0FF);
          write_reg(CFG_CHAR_SPACING, 10'h3FF);
        end
        3: begin
          write_reg(CFG_DOT_SPACING, 10'h000);
          write_reg(CFG_CHAR_SPACING, 10'h000);
        end
        default: begin
          write_reg(CFG_DOT_SPACING, SpaceW'($urandom_range(0, 1023)));
          write_reg(CFG_CHAR_SPACING, SpaceW'($urandom_range(0, 1023)));
          if ($urandom_range(0, 1) != 0) begin
            write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                      SpaceW'($urandom_range(0, 1023)));
          end
        end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (burst_left == 0) begin
          idle_on    = 1'($urandom_range(0, 1));
          burst_left = $urandom_range(5, 20);
        end
        burst_left--;
        if ($urandom_range(0, 3) != 0) begin
          ch = CHAR_FIRST + CharW'($urandom_range(0, 25));
        end else begin
          ch = CharW'($urandom_range(0, 255));
        end
        gap = idle_on ? $urandom_range(0, 10) : 0;
        send_char(ch, gap, NoTally);
      end
    end

    drain();
    if (fault_count == 0) begin
      $display("braille_emboss_command_sequencer verification clean");
    end else begin
      $display("braille_emboss_command_sequencer verification failed");
    end
    $finish;
  end

endmodule
